// ===== src/mnba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnba_pkg: shared types and constants for the major number allocator
// Holds the result status codes, the default parameter values and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package mnba_pkg;

  // Default configuration
  localparam int DEF_NUM_FS_TYPES = 8;
  localparam int DEF_MAP_BITS     = 128;

  // First major number covered by the used map
  localparam logic [7:0] MAJOR_BASE = 8'd128;

  // Result status codes
  typedef enum logic [2:0] {
    ST_GRANTED  = 3'd0,
    ST_FALLBACK = 3'd1,
    ST_FREED    = 3'd2,
    ST_IGNORED  = 3'd3,
    ST_ERROR    = 3'd4
  } status_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;    // latch a request, mark reserved numbers on allocate
    logic do_free;   // evaluate and apply a free request
    logic scan;      // examine one map byte
    logic load_out;  // move the pending result into the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic found;     // current map byte holds a free bit
    logic last;      // current map byte is the last one
    logic out_full;  // output register holds an untaken result
  } dp_sts_t;

endpackage

// ===== src/mnba_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnba_ctrl: request sequencer
// Accepts one request at a time, steps the datapath through a free or a
// byte-wise map scan, and hands the result to the output register.
// ----------------------------------------------------------------------------
module mnba_ctrl import mnba_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    mode,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FREE  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_WRITE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_slot_free;

  assign in_ready      = (state == S_IDLE);
  assign out_slot_free = !sts.out_full || out_ready;

  // Drive datapath commands
  always_comb begin
    cmd          = '0;
    cmd.accept   = (state == S_IDLE) && in_valid;
    cmd.do_free  = (state == S_FREE);
    cmd.scan     = (state == S_SCAN);
    cmd.load_out = (state == S_WRITE) && out_slot_free;
  end

  // Advance the sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = mode ? S_FREE : S_SCAN;
        end
      end
      S_FREE: begin
        state_next = S_WRITE;
      end
      S_SCAN: begin
        if (sts.found || sts.last) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        if (out_slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== src/mnba_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnba_dp: used map and result datapath
// Holds the used map, scans it one byte per cycle for the lowest free bit,
// applies free requests, and keeps the pending and output results.
// ----------------------------------------------------------------------------
module mnba_dp import mnba_pkg::*; #(
  parameter int NUM_FS_TYPES = DEF_NUM_FS_TYPES,
  parameter int MAP_BITS     = DEF_MAP_BITS
) (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  output dp_sts_t    sts,
  input  logic       mode,
  input  logic       type_given,
  input  logic [2:0] fs_type,
  input  logic [7:0] number,
  input  logic       out_ready,
  output logic       out_valid,
  output logic [7:0] major,
  output logic [2:0] status
);

  localparam int NUM_BYTES = (MAP_BITS + 7) / 8;
  localparam int PAD_BITS  = NUM_BYTES * 8;
  localparam int BYTE_W    = (NUM_BYTES > 1) ? $clog2(NUM_BYTES) : 1;

  // Latched request
  logic             req_typed;
  logic [2:0]       req_type;
  logic [7:0]       req_number;

  logic [MAP_BITS-1:0] used_map;
  logic [MAP_BITS-1:0] used_map_next;
  logic [MAP_BITS-1:0] resv_mask;
  logic [PAD_BITS-1:0] padded_map;
  logic [BYTE_W-1:0]   byte_cnt;

  logic [7:0]  pend_major;
  status_t     pend_status;

  logic [7:0]  scan_byte;
  logic [2:0]  pos;
  logic        found;
  logic        last;
  logic [6:0]  grant_idx;
  logic        type_known;
  logic        in_range;
  logic        own_resv;
  logic        free_clears;

  // Reserved numbers and padding bits beyond the map read as used
  for (genvar i = 0; i < MAP_BITS; i++) begin : g_resv
    assign resv_mask[i] = (i < NUM_FS_TYPES);
  end

  for (genvar i = 0; i < PAD_BITS; i++) begin : g_pad
    if (i < MAP_BITS) begin : g_map
      assign padded_map[i] = used_map[i];
    end else begin : g_fill
      assign padded_map[i] = 1'b1;
    end
  end

  // Pick the lowest free bit of the current byte
  assign scan_byte = padded_map[{byte_cnt, 3'b000} +: 8];
  assign found     = !(&scan_byte);
  assign last      = (byte_cnt == BYTE_W'(NUM_BYTES - 1));

  always_comb begin
    pos = 3'd0;
    for (int j = 7; j >= 0; j--) begin
      if (!scan_byte[j]) begin
        pos = 3'(j);
      end
    end
  end

  assign grant_idx = 7'({byte_cnt, pos});

  // Free request checks
  assign type_known  = ({5'd0, req_type} < 8'(NUM_FS_TYPES));
  assign in_range    = req_number[7] && ({1'b0, req_number[6:0]} < 8'(MAP_BITS));
  assign own_resv    = req_typed && type_known && (req_number[6:0] == {4'd0, req_type});
  assign free_clears = in_range && !own_resv;

  // Next map: mark reserved, clear freed bit, claim granted bit
  always_comb begin
    used_map_next = used_map;
    if (cmd.accept && !mode) begin
      used_map_next = used_map | resv_mask;
    end
    for (int i = 0; i < MAP_BITS; i++) begin
      if (cmd.do_free && free_clears && (7'(i) == req_number[6:0])) begin
        used_map_next[i] = 1'b0;
      end
      if (cmd.scan && found && (7'(i) == grant_idx)) begin
        used_map_next[i] = 1'b1;
      end
    end
  end

  // Map, byte counter and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      used_map  <= '0;
      byte_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      used_map <= used_map_next;
      if (cmd.accept) begin
        byte_cnt <= '0;
      end else if (cmd.scan && !found && !last) begin
        byte_cnt <= byte_cnt + BYTE_W'(1);
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request capture and result payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_typed  <= type_given;
      req_type   <= fs_type;
      req_number <= number;
    end
    if (cmd.do_free) begin
      if (!in_range) begin
        pend_major  <= 8'd0;
        pend_status <= ST_ERROR;
      end else if (own_resv) begin
        pend_major  <= req_number;
        pend_status <= ST_IGNORED;
      end else begin
        pend_major  <= req_number;
        pend_status <= ST_FREED;
      end
    end
    if (cmd.scan) begin
      if (found) begin
        pend_major  <= MAJOR_BASE | {1'b0, grant_idx};
        pend_status <= ST_GRANTED;
      end else if (last) begin
        if (req_typed && type_known) begin
          pend_major  <= MAJOR_BASE | {5'd0, req_type};
          pend_status <= ST_FALLBACK;
        end else begin
          pend_major  <= 8'd0;
          pend_status <= ST_ERROR;
        end
      end
    end
    if (cmd.load_out) begin
      major  <= pend_major;
      status <= pend_status;
    end
  end

  assign sts.found    = found;
  assign sts.last     = last;
  assign sts.out_full = out_valid;

endmodule

// ===== src/major_number_bitmap_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// major_number_bitmap_allocator: first-free allocator for majors 128 to 255
// Allocates and frees major numbers against a used map with reserved
// numbers per filesystem type.
// ----------------------------------------------------------------------------
// One request is in flight at a time. A free steps through the free state
// and the write state, where its result is loaded into the output register.
// An allocate scans the used map one byte per cycle from the lowest byte,
// stopping at the first byte that holds a free bit or at the last byte, and
// then moves to the write state, so its result turns valid later the farther
// the first free bit lies. A result that finds the output register still
// holding an untaken result waits, and no new request is taken meanwhile.
// A new request is taken as soon as the previous result sits in the output
// register, even if that result has not yet been taken.
// The used map resets to all free at once; no clearing pass follows reset.
// ----------------------------------------------------------------------------
module major_number_bitmap_allocator import mnba_pkg::*; #(
  parameter int NUM_FS_TYPES = DEF_NUM_FS_TYPES,
  parameter int MAP_BITS     = DEF_MAP_BITS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       mode,
  input  logic       type_given,
  input  logic [2:0] fs_type,
  input  logic [7:0] number,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] major,
  output logic [2:0] status
);

  cmd_t    cmd;
  dp_sts_t sts;

  mnba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mnba_dp #(
    .NUM_FS_TYPES (NUM_FS_TYPES),
    .MAP_BITS     (MAP_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .mode       (mode),
    .type_given (type_given),
    .fs_type    (fs_type),
    .number     (number),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .major      (major),
    .status     (status)
  );

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the major number bitmap allocator
// A queue-fed driver sends allocate and free requests. A monitor keeps its
// own copy of the used map, predicts each result when a request transaction
// is accepted, and checks every returned transaction against the oldest
// prediction. A directed opener comes first. Three random phases follow,
// each with a different idle pattern, and each fills the map to exhaustion.
// ----------------------------------------------------------------------------
module tb_top;
  import mnba_pkg::*;

  localparam int NUM_TYPES  = DEF_NUM_FS_TYPES;
  localparam int MAP_SIZE   = DEF_MAP_BITS;
  localparam int RESV_COUNT = (NUM_TYPES > 128) ? 128 : NUM_TYPES;
  localparam int SCAN_COUNT = (MAP_SIZE > 128) ? 128 : MAP_SIZE;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS  = 380;

  typedef struct packed {
    logic       mode;
    logic       type_given;
    logic [2:0] fs_type;
    logic [7:0] number;
  } req_t;

  typedef struct {
    logic [7:0] major;
    status_t    status;
  } grant_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       mode = MODE_ALLOC;
  logic       type_given = 1'b0;
  logic [2:0] fs_type = 3'd0;
  logic [7:0] number = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] major;
  logic [2:0] status;

  // Bench state
  req_t          request_queue[$];
  grant_t        awaited_results[$];
  logic [127:0]  used_map_model = '0;
  logic          in_taken = 1'b0;
  int            stall_cycles = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            sent_total = 0;
  int            accepted_total = 0;
  int            returned_total = 0;
  int            error_count = 0;
  int            status_seen[5] = '{default: 0};

  major_number_bitmap_allocator #(
    .NUM_FS_TYPES(NUM_TYPES),
    .MAP_BITS    (MAP_SIZE)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .type_given(type_given),
    .fs_type   (fs_type),
    .number    (number),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .major     (major),
    .status    (status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one request to the used map and return the result it should produce
  function automatic grant_t resolve_request(req_t r);
    grant_t g;
    int     idx;
    bit     hit;
    g.major  = '0;
    g.status = ST_ERROR;
    hit      = 1'b0;
    if (r.mode == MODE_ALLOC) begin
      // reserved numbers are always re-marked before the search
      for (int k = 0; k < RESV_COUNT; k++) used_map_model[k] = 1'b1;
      for (int k = 0; k < SCAN_COUNT && !hit; k++) begin
        if (!used_map_model[k]) begin
          used_map_model[k] = 1'b1;
          g.major  = MAJOR_BASE + 8'(k);
          g.status = ST_GRANTED;
          hit      = 1'b1;
        end
      end
      // map full: fall back to the requester's own reserved number
      if (!hit && r.type_given && r.fs_type < NUM_TYPES) begin
        g.major  = MAJOR_BASE + r.fs_type;
        g.status = ST_FALLBACK;
      end
    end else if (r.number >= MAJOR_BASE && (r.number - MAJOR_BASE) < SCAN_COUNT) begin
      idx     = int'(r.number) - int'(MAJOR_BASE);
      g.major = r.number;
      if (r.type_given && r.fs_type < NUM_TYPES && idx == r.fs_type) begin
        g.status = ST_IGNORED;
      end else begin
        used_map_model[idx] = 1'b0;
        g.status = ST_FREED;
      end
    end
    return g;
  endfunction

  task automatic queue_request(logic m, logic t, logic [2:0] ft, logic [7:0] num);
    req_t r;
    r = '{mode: m, type_given: t, fs_type: ft, number: num};
    request_queue.push_back(r);
    sent_total++;
  endtask

  task automatic queue_random_alloc();
    queue_request(MODE_ALLOC, 1'($urandom), 3'($urandom), 8'($urandom));
  endtask

  // Fill the map past exhaustion, then churn with mixed allocates and frees
  task automatic queue_random_phase(int count);
    int pick;
    int t;
    for (int i = 0; i < 125; i++) queue_random_alloc();
    for (int i = 125; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        queue_random_alloc();
      end else if (pick < 80) begin
        queue_request(MODE_FREE, 1'($urandom), 3'($urandom),
                      MAJOR_BASE + 8'($urandom_range(SCAN_COUNT - 1)));
      end else if (pick < 88) begin
        // free of the requester's own reserved number
        t = $urandom_range(NUM_TYPES - 1);
        queue_request(MODE_FREE, 1'b1, 3'(t), MAJOR_BASE + 8'(t));
      end else begin
        queue_request(MODE_FREE, 1'($urandom), 3'($urandom), 8'($urandom));
      end
    end
  endtask

  // Hold until every queued request is accepted and every result is back
  task automatic wait_for_drain();
    while (accepted_total != sent_total || awaited_results.size() != 0) begin
      @(negedge clk);
    end
    @(posedge clk);
  endtask

  // Driver: advance to the next request once the current transaction is taken
  always @(negedge clk) begin : request_driver
    req_t r;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        r = request_queue.pop_front();
        mode       <= r.mode;
        type_given <= r.type_given;
        fs_type    <= r.fs_type;
        number     <= r.number;
        in_valid   <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver backpressure
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: predict on request transactions, check result transactions
  always @(posedge clk) begin : result_monitor
    grant_t want;
    req_t   r;
    if (rst) begin
      in_taken     <= 1'b0;
      stall_cycles <= stall_cycles + 1;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        r = '{mode: mode, type_given: type_given, fs_type: fs_type, number: number};
        awaited_results.push_back(resolve_request(r));
        accepted_total++;
      end
      if (out_valid && out_ready) begin
        returned_total++;
        if (status < 5) status_seen[status]++;
        if (awaited_results.size() == 0) begin
          $display("%0t: result with nothing pending: major %0d status %0d",
                   $realtime, major, status);
          error_count++;
        end else begin
          want = awaited_results.pop_front();
          if (major !== want.major) begin
            $display("%0t: major mismatch: expected %0d, actual %0d",
                     $realtime, want.major, major);
            error_count++;
          end
          if (status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $realtime, want.status, status);
            error_count++;
          end
        end
      end
      stall_cycles <= ((in_valid && in_ready) || (out_valid && out_ready)) ?
                      0 : stall_cycles + 1;
    end
  end

  // Watchdog: end the run if no transaction moves for too long
  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("%0t: no transaction for %0d cycles", $realtime, STALL_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // Stimulus sequence
  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(posedge clk);

    // Directed opener on an empty map
    send_idle_pct = 35;
    recv_idle_pct = 78;
    queue_request(MODE_ALLOC, 1'b0, 3'd0, 8'd0);     // first grant past reserved
    queue_request(MODE_ALLOC, 1'b1, 3'd7, 8'd255);
    queue_request(MODE_FREE,  1'b1, 3'd3, 8'd131);   // own reserved: ignored
    queue_request(MODE_FREE,  1'b1, 3'd2, 8'd131);   // other type's reserved
    queue_request(MODE_FREE,  1'b0, 3'd5, 8'd131);   // already clear
    queue_request(MODE_ALLOC, 1'b1, 3'd4, 8'd170);   // re-marks reserved
    queue_request(MODE_FREE,  1'b0, 3'd0, 8'd0);     // below range
    queue_request(MODE_FREE,  1'b1, 3'd7, 8'd127);   // just below range
    queue_request(MODE_FREE,  1'b0, 3'd0, 8'd255);   // top, never used
    queue_request(MODE_FREE,  1'b1, 3'd0, 8'd128);   // lowest reserved, own
    queue_request(MODE_FREE,  1'b1, 3'd7, 8'd135);   // highest reserved, own
    queue_request(MODE_FREE,  1'b1, 3'd1, 8'd136);   // release a grant
    queue_request(MODE_ALLOC, 1'b0, 3'd7, 8'd85);    // regains the released one
    queue_request(MODE_FREE,  1'b1, 3'd5, 8'd200);
    queue_request(MODE_ALLOC, 1'b0, 3'd7, 8'd255);
    queue_request(MODE_FREE,  1'b1, 3'd7, 8'd255);
    wait_for_drain();

    // Random phases with different idle patterns
    queue_random_phase(PHASE_ITEMS);
    wait_for_drain();

    send_idle_pct = 78;
    recv_idle_pct = 35;
    queue_random_phase(PHASE_ITEMS);
    wait_for_drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_phase(PHASE_ITEMS);
    wait_for_drain();

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d requests, %0d results back; map filled to exhaustion in 3 phases.",
             accepted_total, returned_total);
    $display("Granted %0d, fallback %0d, freed %0d, ignored %0d, error %0d.",
             status_seen[ST_GRANTED], status_seen[ST_FALLBACK], status_seen[ST_FREED],
             status_seen[ST_IGNORED], status_seen[ST_ERROR]);
    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
